// ===== sv/bicubic_bezier_patch_eval_top_assert.svh =====
// Assertion helpers for the patch evaluator checker.
`ifndef BICUBIC_BEZIER_PATCH_EVAL_TOP_ASSERT_SVH
`define BICUBIC_BEZIER_PATCH_EVAL_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBPE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bbpe check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bbpe check failed");

`endif

// ===== sv/bbpe_pkg.sv =====
`default_nettype none
package bbpe_pkg;

	localparam int unsigned PT_COUNT    = 16;
	localparam int unsigned COMP_COUNT  = 4;
	localparam int unsigned BASIS_STEPS = 12;
	localparam int unsigned MAC_SLOTS   = 5;

	localparam logic [15:0] ONE_Q15 = 16'h8000;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASIS,
		ST_PRO,
		ST_MAC,
		ST_DRAIN,
		ST_FIN
	} state_t;

	// multiplier operand selection; the write-back target follows from it
	typedef enum logic [2:0] {
		MUL_UU,
		MUL_PP,
		MUL_UUU,
		MUL_UU3P,
		MUL_PP3U,
		MUL_PPP,
		MUL_CW,
		MUL_MAC
	} mul_op_t;

	typedef struct packed {
		logic       load;
		logic       start;
		logic       mul_en;
		mul_op_t    mul_op;
		logic       sel_t;
		logic [1:0] comp;
		logic       rot_s;
		logic       rot_t;
		logic       rd_en;
		logic [3:0] rd_addr;
		logic       out_load;
	} dp_cmd_t;

	function automatic logic [15:0] clamp_param(input logic [15:0] p);
		return (p > ONE_Q15) ? ONE_Q15 : p;
	endfunction

	// round half up by 2^30, then saturate to signed 32 bits
	function automatic logic signed [31:0] sat_round(input logic signed [63:0] acc);
		logic signed [63:0] sum;
		logic        [33:0] r;
		sum = acc + 64'sd536870912;
		r   = sum[63:30];
		if (!r[33] && (r[32:31] != 2'b00))
			return 32'sh7FFF_FFFF;
		else if (r[33] && (r[32:31] != 2'b11))
			return 32'sh8000_0000;
		else
			return $signed(r[31:0]);
	endfunction

endpackage
`default_nettype wire

// ===== sv/bbpe_if.sv =====
`default_nettype none
interface bbpe_req_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic        [3:0]  point_index;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic signed [31:0] coord_z;
	logic signed [31:0] coord_w;
	logic        [15:0] param_s;
	logic        [15:0] param_t;

	modport source (
		output valid, req_type, point_index, coord_x, coord_y, coord_z, coord_w,
		       param_s, param_t,
		input  ready
	);
	modport sink (
		input  valid, req_type, point_index, coord_x, coord_y, coord_z, coord_w,
		       param_s, param_t,
		output ready
	);
endinterface

interface bbpe_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic signed [31:0] out_w;

	modport source (output valid, out_x, out_y, out_z, out_w, input ready);
	modport sink   (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface
`default_nettype wire

// ===== sv/bicubic_bezier_patch_eval_top.sv =====
// Bicubic Bezier patch evaluator.
// Channel req (valid/ready): one request per accepted edge. A load request
//   (req_type = REQ_LOAD) writes control point point_index (x, y, z, w in
//   signed Q16.16) and returns nothing; loads are taken while the block is
//   idle and may follow one another back to back.
// An evaluate request (req_type = REQ_EVAL) carries s and t in Q1.15 and
//   returns one homogeneous point on channel rsp, saturated Q16.16.
// The result register loads at the end of an evaluation; req.ready returns
//   the cycle after. Cost is set by the single 32x32 multiplier: 12 products
//   for the two Bernstein weight sets, then 16 points times (one combined
//   weight + four component MACs).
// One evaluation is in flight at a time; loads are taken while a finished
//   result still waits in the output register.
// If the receiver stalls, a second evaluation runs to the end and holds
//   until the output register frees up; req.ready stays low meanwhile.
// Reset clears control state only. Control points are undefined until
//   loaded; evaluating over an unloaded point gives an undefined result.
`default_nettype none
module bicubic_bezier_patch_eval_top (
	input  logic       clk,
	input  logic       arst_n,
	bbpe_req_if.sink   req,
	bbpe_rsp_if.source rsp
);
	import bbpe_pkg::*;

	dp_cmd_t cmd;

	// sequencer: request handshake, multiplier schedule, result handshake
	bbpe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// point store, weight registers, shared multiplier and accumulators
	bbpe_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.point_index (req.point_index),
		.coord_x     (req.coord_x),
		.coord_y     (req.coord_y),
		.coord_z     (req.coord_z),
		.coord_w     (req.coord_w),
		.param_s     (req.param_s),
		.param_t     (req.param_t),
		.out_x       (rsp.out_x),
		.out_y       (rsp.out_y),
		.out_z       (rsp.out_z),
		.out_w       (rsp.out_w)
	);

endmodule
`default_nettype wire

// ===== sv/bbpe_ctrl.sv =====
`default_nettype none
module bbpe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_type,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output bbpe_pkg::dp_cmd_t cmd
);
	import bbpe_pkg::*;

	localparam logic [3:0] BASIS_LAST = 4'(BASIS_STEPS - 1);
	localparam logic [3:0] BASIS_HALF = 4'(BASIS_STEPS / 2);
	localparam logic [3:0] PT_LAST    = 4'(PT_COUNT - 1);
	localparam logic [2:0] SLOT_LAST  = 3'(MAC_SLOTS - 1);
	localparam logic [2:0] SLOT_CW    = 3'(MAC_SLOTS - 2);

	state_t     state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic [2:0] slot_q, slot_d;
	logic       out_valid_q;
	logic [3:0] nxt_pt;

	assign nxt_pt    = cnt_q + 4'd1;
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			slot_q  <= slot_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		slot_d    = slot_q;
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_type == REQ_EVAL) begin
						cmd.start = 1'b1;
						cnt_d     = '0;
						state_d   = ST_BASIS;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_BASIS: begin
				// six products per parameter, s first, then t
				cmd.mul_en = 1'b1;
				cmd.sel_t  = (cnt_q >= BASIS_HALF);
				case (cnt_q)
					4'd0, 4'd6:  cmd.mul_op = MUL_UU;
					4'd1, 4'd7:  cmd.mul_op = MUL_PP;
					4'd2, 4'd8:  cmd.mul_op = MUL_UUU;
					4'd3, 4'd9:  cmd.mul_op = MUL_UU3P;
					4'd4, 4'd10: cmd.mul_op = MUL_PP3U;
					default:     cmd.mul_op = MUL_PPP;
				endcase
				if (cnt_q == BASIS_LAST) begin
					slot_d  = '0;
					state_d = ST_PRO;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			ST_PRO: begin
				if (slot_q == 3'd0) begin
					cmd.mul_en  = 1'b1;
					cmd.mul_op  = MUL_CW;
					cmd.rot_s   = 1'b1;
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = '0;
					slot_d      = 3'd1;
				end else begin
					slot_d  = '0;
					cnt_d   = '0;
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				// slots: comp0, comp1, comp2, next weight, comp3
				if (slot_q == SLOT_CW) begin
					if (cnt_q != PT_LAST) begin
						cmd.mul_en = 1'b1;
						cmd.mul_op = MUL_CW;
						cmd.rot_s  = 1'b1;
						cmd.rot_t  = (nxt_pt[1:0] == 2'd3);
					end
				end else begin
					cmd.mul_en = 1'b1;
					cmd.mul_op = MUL_MAC;
					cmd.comp   = (slot_q == SLOT_LAST) ? 2'd3 : slot_q[1:0];
				end
				if (slot_q == SLOT_LAST) begin
					slot_d = '0;
					if (cnt_q == PT_LAST) begin
						state_d = ST_DRAIN;
					end else begin
						cmd.rd_en   = 1'b1;
						cmd.rd_addr = nxt_pt;
						cnt_d       = nxt_pt;
					end
				end else begin
					slot_d = slot_q + 3'd1;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/bbpe_dp.sv =====
`default_nettype none
module bbpe_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  bbpe_pkg::dp_cmd_t  cmd,
	input  logic        [3:0]  point_index,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic signed [31:0] coord_w,
	input  logic        [15:0] param_s,
	input  logic        [15:0] param_t,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic signed [31:0] out_w
);
	import bbpe_pkg::*;

	logic        [127:0] mem [PT_COUNT];
	logic        [127:0] rd_q;
	logic        [15:0]  s_q, t_q;
	logic        [15:0]  p, u;
	logic        [17:0]  p3, u3;
	logic        [30:0]  uu_q, pp_q, cw_q;
	logic        [15:0]  ws_q [4];
	logic        [15:0]  wt_q [4];
	logic signed [63:0]  acc_q [COMP_COUNT];
	logic signed [31:0]  mul_a, mul_b;
	logic signed [63:0]  prod_s1;
	logic                en_s1;
	mul_op_t             op_s1;
	logic                sel_t_s1;
	logic        [1:0]   comp_s1;
	logic        [46:0]  wround;
	logic        [15:0]  wnew;

	assign p  = cmd.sel_t ? t_q : s_q;
	assign u  = ONE_Q15 - p;
	assign p3 = {2'b00, p} + {1'b0, p, 1'b0};
	assign u3 = {2'b00, u} + {1'b0, u, 1'b0};

	always_comb begin
		case (cmd.mul_op)
			MUL_UU: begin
				mul_a = {16'd0, u};
				mul_b = {16'd0, u};
			end
			MUL_PP: begin
				mul_a = {16'd0, p};
				mul_b = {16'd0, p};
			end
			MUL_UUU: begin
				mul_a = {1'b0, uu_q};
				mul_b = {16'd0, u};
			end
			MUL_UU3P: begin
				mul_a = {1'b0, uu_q};
				mul_b = {14'd0, p3};
			end
			MUL_PP3U: begin
				mul_a = {1'b0, pp_q};
				mul_b = {14'd0, u3};
			end
			MUL_PPP: begin
				mul_a = {1'b0, pp_q};
				mul_b = {16'd0, p};
			end
			MUL_CW: begin
				mul_a = {16'd0, ws_q[0]};
				mul_b = {16'd0, wt_q[0]};
			end
			MUL_MAC: begin
				mul_a = {1'b0, cw_q};
				mul_b = $signed(rd_q[{cmd.comp, 5'd0} +: 32]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Bernstein weight rounded half up to Q1.15
	assign wround = {1'b0, prod_s1[45:0]} + 47'd536870912;
	assign wnew   = wround[45:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			en_s1 <= 1'b0;
		else
			en_s1 <= cmd.mul_en;
	end

	always_ff @(posedge clk) begin
		prod_s1  <= mul_a * mul_b;
		op_s1    <= cmd.mul_op;
		sel_t_s1 <= cmd.sel_t;
		comp_s1  <= cmd.comp;
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			mem[point_index] <= {coord_w, coord_z, coord_y, coord_x};
		if (cmd.rd_en)
			rd_q <= mem[cmd.rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			s_q <= clamp_param(param_s);
			t_q <= clamp_param(param_t);
			for (int i = 0; i < COMP_COUNT; i++)
				acc_q[i] <= '0;
		end
		if (cmd.rot_s) begin
			ws_q[0] <= ws_q[1];
			ws_q[1] <= ws_q[2];
			ws_q[2] <= ws_q[3];
			ws_q[3] <= ws_q[0];
		end
		if (cmd.rot_t) begin
			wt_q[0] <= wt_q[1];
			wt_q[1] <= wt_q[2];
			wt_q[2] <= wt_q[3];
			wt_q[3] <= wt_q[0];
		end
		if (en_s1) begin
			case (op_s1)
				MUL_UU:   uu_q <= prod_s1[30:0];
				MUL_PP:   pp_q <= prod_s1[30:0];
				MUL_UUU: begin
					if (sel_t_s1) wt_q[0] <= wnew;
					else          ws_q[0] <= wnew;
				end
				MUL_UU3P: begin
					if (sel_t_s1) wt_q[1] <= wnew;
					else          ws_q[1] <= wnew;
				end
				MUL_PP3U: begin
					if (sel_t_s1) wt_q[2] <= wnew;
					else          ws_q[2] <= wnew;
				end
				MUL_PPP: begin
					if (sel_t_s1) wt_q[3] <= wnew;
					else          ws_q[3] <= wnew;
				end
				MUL_CW:   cw_q <= prod_s1[30:0];
				MUL_MAC:  acc_q[comp_s1] <= acc_q[comp_s1] + prod_s1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_x <= sat_round(acc_q[0]);
			out_y <= sat_round(acc_q[1]);
			out_z <= sat_round(acc_q[2]);
			out_w <= sat_round(acc_q[3]);
		end
	end

endmodule
`default_nettype wire

// ===== sv/bbpe_checker.sv =====
`default_nettype none
`include "bicubic_bezier_patch_eval_top_assert.svh"
module bbpe_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               req_type,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic signed [31:0] out_x,
	input logic signed [31:0] out_y,
	input logic signed [31:0] out_z,
	input logic signed [31:0] out_w
);
	import bbpe_pkg::*;

	// an accepted evaluate request makes the block busy
	`BBPE_ASSERT_NEXT(a_eval_busy, clk, arst_n, req_valid && req_ready && (req_type == REQ_EVAL), !req_ready)
	// a new result only appears at the end of a busy stretch
	`BBPE_ASSERT_IMPL(a_rsp_after_busy, clk, arst_n, $rose(rsp_valid), $past(!req_ready))
	`BBPE_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`BBPE_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(out_w))

endmodule

bind bicubic_bezier_patch_eval_top bbpe_checker u_bbpe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_type  (req.req_type),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.out_x     (rsp.out_x),
	.out_y     (rsp.out_y),
	.out_z     (rsp.out_z),
	.out_w     (rsp.out_w)
);
`default_nettype wire

// ===== sim/bicubic_bezier_patch_eval_top_tb.sv =====
module bicubic_bezier_patch_eval_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bbpe_pkg::*;

	// Receiver hold-off used by the backpressure test. The watchdog allows for
	// it, for two evaluations and for sender gaps.
	localparam int     HOLD_CYCLES    = 600;
	localparam int     WATCHDOG_LIMIT = 5000;
	// Settle time after the queue drains; longer than one evaluation takes.
	localparam int     DRAIN_CYCLES   = 120;
	localparam int     MAX_REPORTS    = 40;
	localparam longint HALF_Q30       = 64'sd1 <<< 29;

	// One request as the sender sees it.
	typedef struct packed {
		logic        req_type;
		logic [3:0]  point_index;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] w;
		logic [15:0] s;
		logic [15:0] t;
	} patch_req_t;

	// Homogeneous point: a control point or an evaluated surface point.
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] w;
	} hpoint_t;

	logic clk;
	logic arst_n;

	bbpe_req_if req_ch ();
	bbpe_rsp_if rsp_ch ();

	bicubic_bezier_patch_eval_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow of the control point store, updated as loads are accepted.
	hpoint_t ctrl_points [PT_COUNT];
	// Surface points still owed by the block, oldest first.
	hpoint_t expected_points [$];
	hpoint_t want_pt;

	int error_count;
	int src_idle_pct;
	int snk_idle_pct;
	// Bumped by the backpressure test; the receiver starts a hold-off on change.
	int hold_seq;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	// Cubic Bernstein weights in Q1.15, each rounded half up from 2^-45 units.
	// Parameters above one clamp to one.
	function automatic logic [3:0][15:0] basis_weights(input logic [15:0] p);
		longint unsigned s;
		longint unsigned u;
		logic [3:0][15:0] wv;
		s = (p > ONE_Q15) ? 64'(ONE_Q15) : 64'(p);
		u = 64'(ONE_Q15) - s;
		wv[0] = 16'((u * u * u + HALF_Q30) >> 30);
		wv[1] = 16'((3 * s * u * u + HALF_Q30) >> 30);
		wv[2] = 16'((3 * s * s * u + HALF_Q30) >> 30);
		wv[3] = 16'((s * s * s + HALF_Q30) >> 30);
		return wv;
	endfunction

	// Round half up by 2^30 (floor after bias), then clip to signed 32 bits.
	function automatic logic [31:0] round_sat32(input longint acc);
		longint r;
		r = (acc + HALF_Q30) >>> 30;
		if (r > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (r < -64'sd2147483648)
			return 32'h8000_0000;
		return r[31:0];
	endfunction

	// Surface point at (s, t): sum over rows and columns of
	// ws[col] * wt[row] * P[row][col], exact in 64 bits.
	function automatic hpoint_t eval_patch(input logic [15:0] ps, input logic [15:0] pt);
		logic [3:0][15:0] ws;
		logic [3:0][15:0] wt;
		longint  ax, ay, az, aw, wgt;
		hpoint_t cp;
		hpoint_t res;
		ws = basis_weights(ps);
		wt = basis_weights(pt);
		ax = 0;
		ay = 0;
		az = 0;
		aw = 0;
		for (int row = 0; row < 4; row++) begin
			for (int col = 0; col < 4; col++) begin
				wgt = longint'(ws[col]) * longint'(wt[row]);
				cp  = ctrl_points[row * 4 + col];
				ax += wgt * longint'($signed(cp.x));
				ay += wgt * longint'($signed(cp.y));
				az += wgt * longint'($signed(cp.z));
				aw += wgt * longint'($signed(cp.w));
			end
		end
		res.x = round_sat32(ax);
		res.y = round_sat32(ay);
		res.z = round_sat32(az);
		res.w = round_sat32(aw);
		return res;
	endfunction

	// ---------------------------------------------------------------- stimulus

	// Load request; s and t are don't-care and get random values.
	function automatic patch_req_t load_req(input logic [3:0] idx, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z, input logic [31:0] w);
		patch_req_t it;
		it.req_type    = REQ_LOAD;
		it.point_index = idx;
		it.x           = x;
		it.y           = y;
		it.z           = z;
		it.w           = w;
		it.s           = 16'($urandom);
		it.t           = 16'($urandom);
		return it;
	endfunction

	// Evaluate request; index and coordinates are don't-care and get random values.
	function automatic patch_req_t eval_req(input logic [15:0] s, input logic [15:0] t);
		patch_req_t it;
		it.req_type    = REQ_EVAL;
		it.point_index = 4'($urandom);
		it.x           = $urandom;
		it.y           = $urandom;
		it.z           = $urandom;
		it.w           = $urandom;
		it.s           = s;
		it.t           = t;
		return it;
	endfunction

	// Mostly full-range coordinates, some extremes, some small values near zero.
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom_range(32'h0014_0000) - 32'h000A_0000;
			default: return $urandom;
		endcase
	endfunction

	// Mostly legal parameters, with the ends of the range and some above one.
	function automatic logic [15:0] rand_param();
		case ($urandom_range(19))
			0: return 16'd0;
			1: return ONE_Q15;
			2, 3: return 16'($urandom);
			default: return 16'($urandom_range(32768));
		endcase
	endfunction

	// Offer one request after a random gap and wait for it to be taken.
	// Valid stays up on return so back-to-back requests need no second NBA.
	task automatic issue_request(input patch_req_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= it.req_type;
		req_ch.point_index <= it.point_index;
		req_ch.coord_x     <= it.x;
		req_ch.coord_y     <= it.y;
		req_ch.coord_z     <= it.z;
		req_ch.coord_w     <= it.w;
		req_ch.param_s     <= it.s;
		req_ch.param_t     <= it.t;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (it.req_type == REQ_LOAD)
			ctrl_points[it.point_index] = {it.x, it.y, it.z, it.w};
		else
			expected_points.push_back(eval_patch(it.s, it.t));
	endtask

	// ---------------------------------------------------------------- tests

	// Fill every point: x at the positive end, y at the negative end, random z,
	// w = 1.0. Then hit the four corners, the middle and clamped parameters.
	task automatic test_directed();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		for (int i = PT_COUNT - 1; i >= 0; i--)
			issue_request(load_req(4'(i), 32'h7FFF_FFFF, 32'h8000_0000, $urandom,
				32'h0001_0000));
		issue_request(eval_req(16'd0, 16'd0));
		issue_request(eval_req(ONE_Q15, ONE_Q15));
		issue_request(eval_req(16'd0, ONE_Q15));
		issue_request(eval_req(ONE_Q15, 16'd0));
		issue_request(eval_req(16'd16384, 16'd16384));
		// above one on both parameters: same as the far corner
		issue_request(eval_req(16'hFFFF, 16'h8001));
	endtask

	// Rounded weights can sum a hair over one; with x and y at the ends of the
	// range that pushes the sums past 32 bits in both directions.
	task automatic test_saturation();
		logic [3:0][15:0] wv;
		logic [15:0]      heavy;
		heavy = 16'd0;
		for (int p = 1; p < ONE_Q15 && heavy == 16'd0; p++) begin
			wv = basis_weights(16'(p));
			if (32'(wv[0]) + wv[1] + wv[2] + wv[3] > 32'(ONE_Q15))
				heavy = 16'(p);
		end
		issue_request(eval_req(heavy, heavy));
		issue_request(eval_req(heavy, 16'd0));
	endtask

	// Random mix of loads and evaluations; every point is already loaded.
	task automatic test_random(input int n_items, input int src_pct, input int snk_pct);
		patch_req_t it;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		repeat (n_items) begin
			if ($urandom_range(99) < 40)
				it = eval_req(rand_param(), rand_param());
			else
				it = load_req(4'($urandom), rand_coord(), rand_coord(), rand_coord(),
					rand_coord());
			issue_request(it);
		end
	endtask

	// Receiver holds off for a long stretch while requests keep coming: one
	// result parks in the output register, a second evaluation finishes behind
	// it and the request side stalls.
	task automatic test_backpressure();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_seq++;
		repeat (8) begin
			issue_request(eval_req(rand_param(), rand_param()));
			issue_request(load_req(4'($urandom), rand_coord(), rand_coord(), rand_coord(),
				rand_coord()));
		end
	endtask

	// ---------------------------------------------------------------- response side

	initial begin : rsp_ready_drive
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_seq) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: out_%s mismatch: expected %h, actual %h", $time, name,
					want, got);
		end
	endfunction

	// Each accepted result against the oldest surface point still owed.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_points.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: result with none expected: expected nothing, actual %h %h %h %h",
						$time, rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z, rsp_ch.out_w);
			end else begin
				want_pt = expected_points.pop_front();
				check_field("x", want_pt.x, rsp_ch.out_x);
				check_field("y", want_pt.y, rsp_ch.out_y);
				check_field("z", want_pt.z, rsp_ch.out_z);
				check_field("w", want_pt.w, rsp_ch.out_w);
			end
		end
	end

	// Ends the run if nothing moves on either channel for too long.
	initial begin : watchdog
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		error_count  = 0;
		hold_seq     = 0;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.req_type    <= REQ_LOAD;
		req_ch.point_index <= '0;
		req_ch.coord_x     <= '0;
		req_ch.coord_y     <= '0;
		req_ch.coord_z     <= '0;
		req_ch.coord_w     <= '0;
		req_ch.param_s     <= '0;
		req_ch.param_t     <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_saturation();
		test_random(370, 24, 81);
		test_backpressure();
		test_random(370, 81, 24);
		test_random(370, 0, 0);
		req_ch.valid <= 1'b0;

		// watchdog covers a result that never shows up
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== bicubic_bezier_patch_eval_top.f =====
+incdir+sv
sv/bbpe_pkg.sv
sv/bbpe_if.sv
sv/bbpe_ctrl.sv
sv/bbpe_dp.sv
sv/bicubic_bezier_patch_eval_top.sv
sv/bbpe_checker.sv
sim/bicubic_bezier_patch_eval_top_tb.sv
